### rtl/rrts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned RingDepthDef = 16;
  localparam int unsigned IdW          = 8;
  localparam int unsigned TimeW        = 16;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned PendW        = 5;
  localparam int unsigned EntryW       = IdW + TimeW;

  localparam logic [TimeW-1:0] QuantumReset = TimeW'(4);

  localparam logic OpAdd   = 1'b0;
  localparam logic OpSlice = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED = 3'd0,
    ST_FULL  = 3'd1,
    ST_RUN   = 3'd2,
    ST_DONE  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_op_t;

endpackage
`default_nettype wire

### rtl/round_robin_time_slice_scheduler_core.sv
// add, full and empty-slice words: result registered in the cycle after accept
// slice of a pending task: result passes the ring RAM read register, then the output register
// throughput: one word per cycle for adds while the output is taken; a slice holds off new words until its result loads
// reset clears indexes, count and output valid; quantum returns to 4
// ring RAM is not cleared, only written entries are ever read
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler_core
// Ring of pending tasks in one RAM; add appends, slice runs the front task
// for up to one quantum and requeues it while time remains.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler_core #(
  parameter int unsigned RING_DEPTH = rrts_pkg::RingDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rrts_pkg::TimeW-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          operation_i,
  input  wire logic [rrts_pkg::IdW-1:0]      task_id_i,
  input  wire logic [rrts_pkg::TimeW-1:0]    burst_time_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [rrts_pkg::StatusW-1:0]  status_o,
  output logic      [rrts_pkg::IdW-1:0]      served_id_o,
  output logic      [rrts_pkg::TimeW-1:0]    run_time_o,
  output logic      [rrts_pkg::TimeW-1:0]    time_left_o,
  output logic      [rrts_pkg::PendW-1:0]    pending_count_o
);

  import rrts_pkg::*;

  localparam int unsigned IW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam logic [CW-1:0] FullCnt = CW'(RING_DEPTH);

  state_e            state_q, state_d;
  logic [TimeW-1:0]  quantum_q;
  ring_op_t          ring_op;
  logic [IW-1:0]     front, back;
  logic [CW-1:0]     count;

  logic              ram_we, ram_re;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  logic              accept;
  logic              load_out;
  status_e           res_status;
  logic [IdW-1:0]    res_id;
  logic [TimeW-1:0]  res_ran, res_left;
  logic [PendW-1:0]  res_pend;

  logic [IdW-1:0]    rd_id;
  logic [TimeW-1:0]  rd_rem, ran, left;

  logic              out_valid_q;
  status_e           status_q;
  logic [IdW-1:0]    served_q;
  logic [TimeW-1:0]  ran_q, left_q;
  logic [PendW-1:0]  pend_q;

  rrts_ram #(
    .WIDTH (EntryW),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (back),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (front),
    .rdata_o (ram_rdata)
  );

  rrts_ptr #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ptr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (ring_op),
    .front_o (front),
    .back_o  (back),
    .count_o (count)
  );

  assign rd_id  = ram_rdata[EntryW-1:TimeW];
  assign rd_rem = ram_rdata[TimeW-1:0];
  assign ran    = (rd_rem < quantum_q) ? rd_rem : quantum_q;
  assign left   = rd_rem - ran;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    accept       = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wdata    = {task_id_i, burst_time_i};
    ring_op      = '0;
    load_out     = 1'b0;
    res_status   = ST_ADDED;
    res_id       = '0;
    res_ran      = '0;
    res_left     = '0;
    res_pend     = PendW'(count);
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        accept     = in_valid_i && in_ready_o;
        if (accept) begin
          if (operation_i == OpAdd) begin
            load_out = 1'b1;
            if (count == FullCnt) begin
              res_status = ST_FULL;
            end else begin
              ram_we       = 1'b1;
              ring_op.push = 1'b1;
              res_status   = ST_ADDED;
              res_pend     = PendW'(count + CW'(1));
            end
          end else if (count == '0) begin
            load_out   = 1'b1;
            res_status = ST_EMPTY;
            res_pend   = '0;
          end else begin
            ram_re  = 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        load_out    = 1'b1;
        ring_op.pop = 1'b1;
        res_id      = rd_id;
        res_ran     = ran;
        res_left    = left;
        ram_wdata   = {rd_id, left};
        if (left != '0) begin
          ram_we       = 1'b1;
          ring_op.push = 1'b1;
          res_status   = ST_RUN;
        end else begin
          res_status = ST_DONE;
          res_pend   = PendW'(count - CW'(1));
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      quantum_q   <= QuantumReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= res_status;
      served_q <= res_id;
      ran_q    <= res_ran;
      left_q   <= res_left;
      pend_q   <= res_pend;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign served_id_o     = served_q;
  assign run_time_o      = ran_q;
  assign time_left_o     = left_q;
  assign pending_count_o = pend_q;

endmodule
`default_nettype wire

### rtl/rrts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/rrts_ptr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_ptr
// Front and back indexes and task count of the ring.
// ----------------------------------------------------------------------------
module rrts_ptr #(
  parameter int unsigned RING_DEPTH = 16,
  localparam int unsigned IW        = $clog2(RING_DEPTH),
  localparam int unsigned CW        = $clog2(RING_DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rrts_pkg::ring_op_t op_i,
  output logic      [IW-1:0]     front_o,
  output logic      [IW-1:0]     back_o,
  output logic      [CW-1:0]     count_o
);

  import rrts_pkg::*;

  localparam logic [IW-1:0] LastIdx = IW'(RING_DEPTH - 1);

  logic [IW-1:0] front_q, front_d;
  logic [IW-1:0] back_q, back_d;
  logic [CW-1:0] count_q, count_d;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    next_slot = (i == LastIdx) ? '0 : i + IW'(1);
  endfunction

  always_comb begin
    front_d = op_i.pop  ? next_slot(front_q) : front_q;
    back_d  = op_i.push ? next_slot(back_q)  : back_q;
    unique case ({op_i.push, op_i.pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  assign front_o = front_q;
  assign back_o  = back_q;
  assign count_o = count_q;

endmodule
`default_nettype wire
